### src/sszt_pkg.sv
// ----------------------------------------------------------------------------
// sszt_pkg
// shared widths, command codes and control types of the subset sum engine
// ----------------------------------------------------------------------------
package sszt_pkg;

	localparam int CMD_W        = 3;
	localparam int MASK_INDEX_W = 10;
	localparam int OPERAND_W    = 32;
	localparam int WORD_W       = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET     = 3'd0,
		CMD_INC     = 3'd1,
		CMD_GET     = 3'd2,
		CMD_SUB_SUM = 3'd3,
		CMD_SUB_INV = 3'd4,
		CMD_SUP_SUM = 3'd5,
		CMD_SUP_INV = 3'd6
	} cmd_t;

	// what the read-modify-write stage does with one memory access
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET,
		OP_ADD_VAL,
		OP_GET,
		OP_ADD_SRC,
		OP_SUB_SRC
	} op_t;

	typedef struct packed {
		logic v;
		op_t  op;
		logic push;
	} req_t;

endpackage

### src/sszt_if.sv
// ----------------------------------------------------------------------------
// sszt_req_if / sszt_rsp_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface sszt_req_if import sszt_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            cmd;
	logic [MASK_INDEX_W-1:0]     mask_index;
	logic signed [OPERAND_W-1:0] operand_value;

	modport source(output valid, cmd, mask_index, operand_value, input ready);
	modport sink(input valid, cmd, mask_index, operand_value, output ready);
endinterface

interface sszt_rsp_if import sszt_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_value;

	modport source(output valid, read_value, input ready);
	modport sink(input valid, read_value, output ready);
endinterface

### src/sszt_mem.sv
// ----------------------------------------------------------------------------
// sszt_mem
// word store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module sszt_mem import sszt_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [INDEX_BITS-1:0] wa,
	input  logic [WORD_W-1:0]     wd,
	input  logic [INDEX_BITS-1:0] ra_a,
	input  logic [INDEX_BITS-1:0] ra_b,
	output logic [WORD_W-1:0]     rd_a,
	output logic [WORD_W-1:0]     rd_b
);

	localparam int DEPTH = 1 << INDEX_BITS;

	logic [WORD_W-1:0] words_q [DEPTH];

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			words_q[wa] <= wd;
		end
		rd_a <= words_q[ra_a];
		rd_b <= words_q[ra_b];
	end

endmodule

### src/sszt_ctrl.sv
// ----------------------------------------------------------------------------
// sszt_ctrl
// command decode, clearing sweep and transform sequencer
// ----------------------------------------------------------------------------
module sszt_ctrl import sszt_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sszt_req_if.sink                    req,
	input  logic                        room,
	output req_t                        op_req,
	output logic [INDEX_BITS-1:0]       addr_a,
	output logic [INDEX_BITS-1:0]       addr_b,
	output logic signed [OPERAND_W-1:0] value
);

	localparam int BW = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
	localparam logic [INDEX_BITS-1:0] K_LAST =
		INDEX_BITS'((64'd1 << (INDEX_BITS - 1)) - 64'd1);
	localparam logic [BW-1:0] B_LAST = BW'(INDEX_BITS - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_XFORM
	} state_t;

	state_t                state_q;
	logic [INDEX_BITS-1:0] cnt_q;
	logic [BW-1:0]         bit_q;
	logic                  super_q;
	logic                  inv_q;

	cmd_t                  cmd;
	logic                  accept;
	logic                  is_xform;
	logic [INDEX_BITS-1:0] idx;
	logic [INDEX_BITS-1:0] low_mask;
	logic [INDEX_BITS-1:0] lo;
	logic [INDEX_BITS-1:0] hi;

	always_comb begin
		cmd      = cmd_t'(req.cmd);
		idx      = INDEX_BITS'(req.mask_index);
		is_xform = (cmd == CMD_SUB_SUM) || (cmd == CMD_SUB_INV) ||
		           (cmd == CMD_SUP_SUM) || (cmd == CMD_SUP_INV);
		// pair counter with a zero spliced in at the current bit position
		low_mask = ~({INDEX_BITS{1'b1}} << bit_q);
		lo       = (((cnt_q >> bit_q) << 1) << bit_q) | (cnt_q & low_mask);
		hi       = lo | (INDEX_BITS'(1) << bit_q);

		req.ready = (state_q == ST_IDLE) && room;
		accept    = req.valid && req.ready;

		op_req = '{v: 1'b0, op: OP_NONE, push: 1'b0};
		addr_a = idx;
		addr_b = lo;
		value  = req.operand_value;
		case (state_q)
			ST_CLEAR: begin
				op_req = '{v: 1'b1, op: OP_SET, push: 1'b0};
				addr_a = cnt_q;
				value  = '0;
			end
			ST_IDLE: begin
				if (accept) begin
					op_req.v    = 1'b1;
					op_req.push = 1'b1;
					case (cmd)
						CMD_SET: op_req.op = OP_SET;
						CMD_INC: op_req.op = OP_ADD_VAL;
						CMD_GET: op_req.op = OP_GET;
						default: op_req.op = OP_NONE;
					endcase
				end
			end
			ST_XFORM: begin
				op_req.v  = 1'b1;
				op_req.op = inv_q ? OP_SUB_SRC : OP_ADD_SRC;
				addr_a    = super_q ? lo : hi;
				addr_b    = super_q ? hi : lo;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			bit_q   <= '0;
			super_q <= 1'b0;
			inv_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + INDEX_BITS'(1);
					if (cnt_q == {INDEX_BITS{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_xform) begin
						state_q <= ST_XFORM;
						cnt_q   <= '0;
						bit_q   <= '0;
						super_q <= (cmd == CMD_SUP_SUM) || (cmd == CMD_SUP_INV);
						inv_q   <= (cmd == CMD_SUB_INV) || (cmd == CMD_SUP_INV);
					end
				end
				ST_XFORM: begin
					if (cnt_q == K_LAST) begin
						cnt_q <= '0;
						if (bit_q == B_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							bit_q <= bit_q + BW'(1);
						end
					end else begin
						cnt_q <= cnt_q + INDEX_BITS'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### src/sszt_rmw.sv
// ----------------------------------------------------------------------------
// sszt_rmw
// second stage: takes read data, forwards the last write, computes write-back
// ----------------------------------------------------------------------------
module sszt_rmw import sszt_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  req_t                        op_req,
	input  logic [INDEX_BITS-1:0]       addr_a,
	input  logic [INDEX_BITS-1:0]       addr_b,
	input  logic signed [OPERAND_W-1:0] value,
	input  logic [WORD_W-1:0]           rd_a,
	input  logic [WORD_W-1:0]           rd_b,
	output logic                        we,
	output logic [INDEX_BITS-1:0]       wa,
	output logic [WORD_W-1:0]           wd,
	output logic                        push,
	output logic [WORD_W-1:0]           push_data
);

	req_t                        req_s1;
	logic [INDEX_BITS-1:0]       addr_a_s1;
	logic [INDEX_BITS-1:0]       addr_b_s1;
	logic signed [OPERAND_W-1:0] value_s1;

	logic                        fwd_v_q;
	logic [INDEX_BITS-1:0]       fwd_addr_q;
	logic [WORD_W-1:0]           fwd_data_q;

	logic [WORD_W-1:0]           a_val;
	logic [WORD_W-1:0]           b_val;
	logic [WORD_W-1:0]           ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1  <= '0;
			fwd_v_q <= 1'b0;
		end else begin
			req_s1  <= op_req;
			fwd_v_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		addr_a_s1  <= addr_a;
		addr_b_s1  <= addr_b;
		value_s1   <= value;
		fwd_addr_q <= wa;
		fwd_data_q <= wd;
	end

	always_comb begin
		// the write of the previous cycle is not yet in the read data
		a_val = (fwd_v_q && (fwd_addr_q == addr_a_s1)) ? fwd_data_q : rd_a;
		b_val = (fwd_v_q && (fwd_addr_q == addr_b_s1)) ? fwd_data_q : rd_b;
		ext   = {{(WORD_W - OPERAND_W){value_s1[OPERAND_W-1]}}, value_s1};

		we        = 1'b0;
		wa        = addr_a_s1;
		wd        = ext;
		push_data = '0;
		if (req_s1.v) begin
			case (req_s1.op)
				OP_SET: we = 1'b1;
				OP_ADD_VAL: begin
					we = 1'b1;
					wd = a_val + ext;
				end
				OP_GET: push_data = a_val;
				OP_ADD_SRC: begin
					we = 1'b1;
					wd = a_val + b_val;
				end
				OP_SUB_SRC: begin
					we = 1'b1;
					wd = a_val - b_val;
				end
				default: ;
			endcase
		end
		push = req_s1.v && req_s1.push;
	end

endmodule

### src/sszt_outq.sv
// ----------------------------------------------------------------------------
// sszt_outq
// two-entry result queue in front of the result channel
// ----------------------------------------------------------------------------
module sszt_outq import sszt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WORD_W-1:0] push_data,
	sszt_rsp_if.source        rsp,
	output logic [1:0]        level,
	output logic              pop
);

	logic [WORD_W-1:0] data_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;

	always_comb begin
		rsp.valid      = (cnt_q != 2'd0);
		rsp.read_value = data_q[rd_q];
		pop            = rsp.valid && rsp.ready;
		level          = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_q] <= push_data;
		end
	end

endmodule

### src/subset_sum_zeta_transform.sv
// ----------------------------------------------------------------------------
// subset_sum_zeta_transform: bitmask-indexed word table with subset/superset transforms
// set, increment and get: one beat per cycle while the result queue has room
// transforms: 1 beat, then busy, one pair per cycle
// through the single write port of the table memory
// after reset the table is swept to zero with no beat accepted
// ----------------------------------------------------------------------------
module subset_sum_zeta_transform import sszt_pkg::*; #(
	parameter int INDEX_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	sszt_req_if.sink   req,
	sszt_rsp_if.source rsp
);

	req_t                        op_req;
	logic [INDEX_BITS-1:0]       addr_a;
	logic [INDEX_BITS-1:0]       addr_b;
	logic signed [OPERAND_W-1:0] value;
	logic [WORD_W-1:0]           rd_a;
	logic [WORD_W-1:0]           rd_b;
	logic                        we;
	logic [INDEX_BITS-1:0]       wa;
	logic [WORD_W-1:0]           wd;
	logic                        push;
	logic [WORD_W-1:0]           push_data;
	logic [1:0]                  level;
	logic                        pop;
	logic [1:0]                  occ;
	logic                        room;

	// a new beat needs a queue slot after the one still in the second stage
	always_comb begin
		occ  = level + {1'b0, push};
		room = pop ? (occ <= 2'd2) : (occ <= 2'd1);
	end

	sszt_ctrl #(.INDEX_BITS(INDEX_BITS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.room   (room),
		.op_req (op_req),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.value  (value)
	);

	sszt_mem #(.INDEX_BITS(INDEX_BITS)) u_mem (
		.clk  (clk),
		.we   (we),
		.wa   (wa),
		.wd   (wd),
		.ra_a (addr_a),
		.ra_b (addr_b),
		.rd_a (rd_a),
		.rd_b (rd_b)
	);

	sszt_rmw #(.INDEX_BITS(INDEX_BITS)) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_req    (op_req),
		.addr_a    (addr_a),
		.addr_b    (addr_b),
		.value     (value),
		.rd_a      (rd_a),
		.rd_b      (rd_b),
		.we        (we),
		.wa        (wa),
		.wd        (wd),
		.push      (push),
		.push_data (push_data)
	);

	sszt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.rsp       (rsp),
		.level     (level),
		.pop       (pop)
	);

endmodule

### src/sszt_chk.sv
// ----------------------------------------------------------------------------
// sszt_chk
// port-level checks of the subset sum engine, bound to the top level
// ----------------------------------------------------------------------------
module sszt_chk import sszt_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_ready,
	input logic [CMD_W-1:0]         req_cmd,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic signed [WORD_W-1:0] rsp_read_value
);

	logic [2:0] pend_q;
	logic       req_beat;
	logic       rsp_beat;
	logic       xform_beat;

	always_comb begin
		req_beat   = req_valid && req_ready;
		rsp_beat   = rsp_valid && rsp_ready;
		xform_beat = req_beat &&
		             ((req_cmd == CMD_SUB_SUM) || (req_cmd == CMD_SUB_INV) ||
		              (req_cmd == CMD_SUP_SUM) || (req_cmd == CMD_SUP_INV));
	end

	// beats taken whose result has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			case ({req_beat, rsp_beat})
				2'b10:   pend_q <= pend_q + 3'd1;
				2'b01:   pend_q <= pend_q - 3'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_read_value))
		else $error("result payload changed while stalled");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !req_ready)
		else $error("command taken during the clearing sweep");

	a_xform_busy: assert property (@(posedge clk) disable iff (!arst_n)
		xform_beat |=> !req_ready)
		else $error("command taken while a transform runs");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 3'd0))
		else $error("result beat without a pending command");

endmodule

bind subset_sum_zeta_transform sszt_chk u_sszt_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_cmd        (req.cmd),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value)
);

### tb/tb_subset_sum_zeta_transform.sv
// ----------------------------------------------------------------------------
// tb_subset_sum_zeta_transform
// checks set/increment/get and the four subset/superset transforms of the
// word table against an in-bench table model; bursty sender, stalling
// receiver, every result beat compared in order
// ----------------------------------------------------------------------------
module tb_subset_sum_zeta_transform;
	import sszt_pkg::*;

	localparam int TBL_BITS       = 10;
	localparam int TBL_SIZE       = 1 << TBL_BITS;
	localparam int N_RANDOM       = 675;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MAX_PRINTS     = 20;

	// the one code the package leaves out: the engine ignores it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	typedef struct {
		logic [CMD_W-1:0]            cmd;
		logic [MASK_INDEX_W-1:0]     mask_index;
		logic signed [OPERAND_W-1:0] operand_value;
	} cmd_beat_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_SLOW
	} rx_mode_t;

	logic clk;
	logic arst_n;

	sszt_req_if req_ch ();
	sszt_rsp_if rsp_ch ();

	subset_sum_zeta_transform #(
		.INDEX_BITS(TBL_BITS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// table model and result bookkeeping
	logic [WORD_W-1:0] word_table [0:TBL_SIZE-1];
	cmd_beat_t         pending_beats[$];
	logic [WORD_W-1:0] expected_words[$];
	cmd_beat_t         cur_beat;
	int                burst_left;
	int                gap_left;
	int                n_by_cmd [0:7];
	int                n_results;
	int                err_count;
	int                idle_cycles;
	rx_mode_t          rx_mode;
	int                rx_mode_left;
	int                rx_phase;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// one bit position at a time; each (without bit, with bit) pair once
	function automatic void transform_table(logic [CMD_W-1:0] cmd);
		int lo;
		for (int b = 0; b < TBL_BITS; b++) begin
			for (int j = 0; j < TBL_SIZE; j++) begin
				if (j[b]) begin
					lo = j ^ (1 << b);
					case (cmd)
						CMD_SUB_SUM: word_table[j]  = word_table[j] + word_table[lo];
						CMD_SUB_INV: word_table[j]  = word_table[j] - word_table[lo];
						CMD_SUP_SUM: word_table[lo] = word_table[lo] + word_table[j];
						default:     word_table[lo] = word_table[lo] - word_table[j];
					endcase
				end
			end
		end
	endfunction

	function automatic logic [WORD_W-1:0] table_step(cmd_beat_t b);
		logic [WORD_W-1:0]   ext;
		logic [TBL_BITS-1:0] idx;
		logic [WORD_W-1:0]   word;
		ext  = {{(WORD_W-OPERAND_W){b.operand_value[OPERAND_W-1]}}, b.operand_value};
		idx  = b.mask_index[TBL_BITS-1:0];
		word = '0;
		case (b.cmd)
			CMD_SET: word_table[idx] = ext;
			CMD_INC: word_table[idx] = word_table[idx] + ext;
			CMD_GET: word = word_table[idx];
			CMD_SUB_SUM, CMD_SUB_INV, CMD_SUP_SUM, CMD_SUP_INV: transform_table(b.cmd);
			default: ;
		endcase
		return word;
	endfunction

	task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
			logic [WORD_W-1:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch at result %0d: %s, got %h, want %h",
				n_results, what, got, want);
		err_count++;
	endtask

	task automatic queue_beat(logic [CMD_W-1:0] cmd, int idx, logic signed [OPERAND_W-1:0] v);
		cmd_beat_t b;
		b.cmd           = cmd;
		b.mask_index    = idx[MASK_INDEX_W-1:0];
		b.operand_value = v;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		int        pick;
		pick = $urandom_range(0, 99);
		if (pick < 27)
			b.cmd = CMD_SET;
		else if (pick < 50)
			b.cmd = CMD_INC;
		else if (pick < 94)
			b.cmd = CMD_GET;
		else if (pick < 97)
			b.cmd = 3'($urandom_range(CMD_SUB_SUM, CMD_SUP_INV));
		else
			b.cmd = CMD_UNUSED;
		// half the accesses crowd a few low entries so they get reused
		if ($urandom_range(0, 1))
			b.mask_index = MASK_INDEX_W'($urandom_range(0, 15));
		else
			b.mask_index = MASK_INDEX_W'($urandom);
		case ($urandom_range(0, 19))
			0:       b.operand_value = 32'sh7fff_ffff;
			1:       b.operand_value = 32'sh8000_0000;
			2:       b.operand_value = -32'sd1;
			3:       b.operand_value = '0;
			default: b.operand_value = $urandom;
		endcase
		return b;
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_words.insert(expected_words.size(), table_step(cur_beat));
				n_by_cmd[cur_beat.cmd]++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					cur_beat = pending_beats.pop_front();
					req_ch.cmd           <= cur_beat.cmd;
					req_ch.mask_index    <= cur_beat.mask_index;
					req_ch.operand_value <= cur_beat.operand_value;
					req_ch.valid         <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between free-running, random and slow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_words.size() == 0)
					report_mismatch("result beat with nothing outstanding",
						rsp_ch.read_value, '0);
				else if (rsp_ch.read_value !== expected_words[0])
					report_mismatch("read_value", rsp_ch.read_value, expected_words[0]);
				if (expected_words.size() != 0)
					void'(expected_words.pop_front());
				n_results++;
			end
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 2));
				rx_mode_left = $urandom_range(16, 200);
			end else begin
				rx_mode_left--;
			end
			rx_phase++;
			case (rx_mode)
				RX_FREE:   rsp_ch.ready <= 1'b1;
				RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
				default:   rsp_ch.ready <= (rx_phase % 4 == 0);
			endcase
		end
	end

	// ends the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, expected_words.size());
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.cmd           = '0;
		req_ch.mask_index    = '0;
		req_ch.operand_value = '0;
		rsp_ch.ready         = 1'b0;
		burst_left           = 0;
		gap_left             = 0;
		n_results            = 0;
		err_count            = 0;
		idle_cycles          = 0;
		rx_mode              = RX_FREE;
		rx_mode_left         = 0;
		rx_phase             = 0;
		foreach (n_by_cmd[i]) n_by_cmd[i] = 0;
		foreach (word_table[i]) word_table[i] = '0;

		// directed: cleared table, field extremes, wraparound, ignored code,
		// then each transform followed by reads
		queue_beat(CMD_GET, TBL_SIZE - 1, '0);
		queue_beat(CMD_SET, 0, 32'sh7fff_ffff);
		queue_beat(CMD_SET, TBL_SIZE - 1, 32'sh8000_0000);
		queue_beat(CMD_INC, TBL_SIZE - 1, -32'sd1);
		queue_beat(CMD_INC, 0, 32'sh7fff_ffff);
		queue_beat(CMD_GET, 0, '0);
		queue_beat(CMD_GET, TBL_SIZE - 1, '0);
		queue_beat(CMD_UNUSED, 0, -32'sd1);
		queue_beat(CMD_GET, 0, '0);
		queue_beat(CMD_SET, 5, 32'sd12345);
		queue_beat(CMD_SET, 513, -32'sd7);
		queue_beat(CMD_SUB_SUM, 0, '0);
		queue_beat(CMD_GET, TBL_SIZE - 1, '0);
		queue_beat(CMD_GET, 5, '0);
		queue_beat(CMD_SUB_INV, 0, '0);
		queue_beat(CMD_GET, 0, '0);
		queue_beat(CMD_SUP_SUM, TBL_SIZE - 1, -32'sd1);
		queue_beat(CMD_GET, 0, '0);
		queue_beat(CMD_SUP_INV, 0, '0);
		queue_beat(CMD_GET, TBL_SIZE - 1, '0);
		queue_beat(CMD_SET, TBL_SIZE - 1, '0);
		queue_beat(CMD_INC, TBL_SIZE - 1, 32'sh8000_0000);
		queue_beat(CMD_INC, TBL_SIZE - 1, 32'sh8000_0000);
		queue_beat(CMD_GET, TBL_SIZE - 1, '0);
		queue_beat(CMD_GET, 5, '0);
		for (int i = 0; i < N_RANDOM; i++)
			pending_beats.insert(pending_beats.size(), random_beat());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || req_ch.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d results: %0d set, %0d increment, %0d get, %0d ignored code",
			n_results, n_by_cmd[CMD_SET], n_by_cmd[CMD_INC], n_by_cmd[CMD_GET],
			n_by_cmd[CMD_UNUSED]);
		$display("transforms: %0d subset sum, %0d subset inverse, %0d superset sum, %s",
			n_by_cmd[CMD_SUB_SUM], n_by_cmd[CMD_SUB_INV], n_by_cmd[CMD_SUP_SUM],
			$sformatf("%0d superset inverse", n_by_cmd[CMD_SUP_INV]));
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
